FILE: hw/rtl/dfss_pkg.sv
`default_nettype none

package dfss_pkg;

	localparam int POS_W   = 14;
	localparam int COORD_W = 12;
	localparam int Q16_W   = 16;

	typedef logic [1:0] req_t;
	localparam req_t REQ_CHECK  = 2'd0;
	localparam req_t REQ_EVAL   = 2'd1;
	localparam req_t REQ_UPDATE = 2'd2;

	localparam logic ADDR_ARENA_WIDTH  = 1'b0;
	localparam logic ADDR_RESET_CHANCE = 1'b1;

	localparam logic [COORD_W-1:0] ARENA_WIDTH_RST  = 12'd1024;
	localparam logic [Q16_W-1:0]   RESET_CHANCE_RST = 16'd66;
	localparam logic [POS_W-1:0]   FLY_INVALID      = '1;
	localparam logic [COORD_W-1:0] COORD_MAX        = '1;

	typedef struct packed {
		logic [COORD_W-1:0] fit;
		logic [COORD_W-1:0] pos;
	} fly_eval_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_RD,
		ST_EV_FIT,
		ST_EV_NB_LAST,
		ST_EV_NB_END,
		ST_EV_NB_ZERO,
		ST_UP_RD,
		ST_UP_MUL,
		ST_UP_ADD
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dispersive_flies_swarm_step_core.sv
`default_nettype none

// One-dimensional dispersive flies step engine over a ring of FLY_COUNT flies.
// Command channel: an item is taken at a rising edge with start high and busy
// low; busy stays high while the item is worked. Result channel: done is high
// for exactly one cycle with fly_position, best_position and was_replaced; the
// beat is taken at the edge ending that cycle and cannot be held off. busy is
// already low during the done cycle, so the next item may start there.
// Steps from accept to done:
//   evaluate           one fly read port: a read state and a fitness state
//                      per fly, then three neighbour writes for the ring
//                      ends
//   check, disturbance read, then write back
//   move update        read, multiply, then add, truncate and saturate
//   out-of-range index or unknown request: done with no work state
// Configuration goes through the APB port at 0x0 (arena_width) and 0x4
// (reset_chance); write it only while idle. Reset sets every fly out of range,
// the best position to zero and the registers to their defaults at once, with
// no clearing pass.
module dispersive_flies_swarm_step_core
	import dfss_pkg::*;
#(
	parameter int FLY_COUNT = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 req_type,
	input  wire logic [4:0]                 fly_index,
	input  wire logic [COORD_W-1:0]         target_position,
	input  wire logic [COORD_W-1:0]         fresh_position,
	input  wire logic [Q16_W-1:0]           reset_draw,
	input  wire logic [Q16_W-1:0]           step_fraction,
	output logic                            done,
	output logic signed [POS_W-1:0]        fly_position,
	output logic [COORD_W-1:0]              best_position,
	output logic                            was_replaced,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [2:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int AW = $clog2(FLY_COUNT);
	localparam int CW = $clog2(FLY_COUNT + 1);

	state_t state_q, state_d;

	logic [COORD_W-1:0] arena_width_q;
	logic [Q16_W-1:0]   reset_chance_q;

	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [FLY_COUNT-1:0] fly_vld_q;
	logic                 fly_vld_rd_q;
	logic [COORD_W-1:0]   best_pos_q;
	logic [COORD_W-1:0]   best_fit_q;

	req_t               kind_q;
	logic [AW-1:0]      idx_q;
	logic [COORD_W-1:0] target_q;
	logic [COORD_W-1:0] fresh_q;
	logic               disturb_q;
	logic [Q16_W-1:0]   frac_q;

	fly_eval_t win_q [3];
	fly_eval_t first0_q, first1_q;

	logic signed [32:0]  prod_q;
	logic [COORD_W-1:0]  nb_q;

	logic signed [POS_W-1:0] fly_position_q;
	logic [COORD_W-1:0]      best_out_q;
	logic                    replaced_q;

	logic accept, start_eval, start_fly, idx_ok;
	logic cfg_wr;

	logic [AW-1:0]      fly_raddr;
	logic               fly_we;
	logic [POS_W-1:0]   fly_wdata;
	logic [POS_W-1:0]   fly_rdata;
	logic [COORD_W-1:0] nb_rdata;
	logic               nb_we;
	logic [AW-1:0]      nb_waddr;
	logic [COORD_W-1:0] nb_wdata;
	fly_eval_t          nb_left, nb_right;
	logic               finish;
	logic [POS_W-1:0]   res_pos;
	logic               res_repl;

	logic signed [POS_W-1:0] x_cur;
	logic signed [15:0]      dist_d;
	logic [15:0]             dist_abs;
	fly_eval_t               cur_eval;
	logic                    oor;
	logic signed [15:0]      diff_d;
	logic signed [32:0]      prod_d;
	logic signed [33:0]      sum_d;
	logic                    round_up;
	logic signed [17:0]      quo_d;
	logic [POS_W-1:0]        sat_d;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == ADDR_RESET_CHANCE) ? {16'd0, reset_chance_q}
	                                                : {20'd0, arena_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_width_q  <= ARENA_WIDTH_RST;
			reset_chance_q <= RESET_CHANCE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ADDR_ARENA_WIDTH) begin
				arena_width_q <= pwdata[COORD_W-1:0];
			end else begin
				reset_chance_q <= pwdata[Q16_W-1:0];
			end
		end
	end

	// command decode
	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign idx_ok     = ({27'd0, fly_index} < 32'(FLY_COUNT));
	assign start_eval = (req_type == REQ_EVAL);
	assign start_fly  = ((req_type == REQ_CHECK) || (req_type == REQ_UPDATE)) && idx_ok;

	// fly datapath
	assign x_cur    = fly_vld_rd_q ? fly_rdata : FLY_INVALID;
	assign dist_d   = $signed({4'd0, target_q}) - $signed({{2{x_cur[POS_W-1]}}, x_cur});
	assign dist_abs = dist_d[15] ? 16'(-dist_d) : dist_d;
	assign cur_eval.fit = (dist_abs[15:12] != 4'd0) ? COORD_MAX : dist_abs[11:0];
	assign cur_eval.pos = x_cur[13] ? '0 : (x_cur[12] ? COORD_MAX : x_cur[11:0]);
	assign oor      = x_cur[13] || (x_cur[12:0] > {1'b0, arena_width_q});
	assign diff_d   = $signed({4'd0, best_pos_q}) - $signed({{2{x_cur[POS_W-1]}}, x_cur});
	assign prod_d   = $signed({1'b0, frac_q}) * diff_d;
	assign sum_d    = $signed({6'd0, nb_q, 16'd0}) + $signed({prod_q[32], prod_q});
	assign round_up = sum_d[33] && (sum_d[15:0] != 16'd0);
	assign quo_d    = $signed(sum_d[33:16]) + $signed({17'd0, round_up});
	assign sat_d    = (quo_d > 18'sd8191) ? POS_W'(8191)
	                : (quo_d < -18'sd8192) ? POS_W'(-8192) : quo_d[POS_W-1:0];
	assign nb_wdata = (nb_left.fit < nb_right.fit) ? nb_left.pos : nb_right.pos;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (start_eval) state_d = ST_EV_RD;
					else if (start_fly) state_d = ST_UP_RD;
				end
			end
			ST_EV_RD:      state_d = ST_EV_FIT;
			ST_EV_FIT:     state_d = (cnt_q == CW'(FLY_COUNT - 1)) ? ST_EV_NB_LAST : ST_EV_RD;
			ST_EV_NB_LAST: state_d = ST_EV_NB_END;
			ST_EV_NB_END:  state_d = ST_EV_NB_ZERO;
			ST_EV_NB_ZERO: state_d = ST_IDLE;
			ST_UP_RD:      state_d = ST_UP_MUL;
			ST_UP_MUL: begin
				state_d = ((kind_q == REQ_UPDATE) && !disturb_q) ? ST_UP_ADD : ST_IDLE;
			end
			ST_UP_ADD:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		fly_raddr = idx_q;
		fly_we    = 1'b0;
		fly_wdata = x_cur;
		nb_we     = 1'b0;
		nb_waddr  = '0;
		nb_left   = win_q[2];
		nb_right  = win_q[0];
		finish    = 1'b0;
		res_repl  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				finish = accept && !start_eval && !start_fly;
			end
			ST_EV_RD: begin
				fly_raddr = cnt_q[AW-1:0];
				nb_we     = (cnt_q >= CW'(3));
				nb_waddr  = cnt_q[AW-1:0] - AW'(2);
			end
			ST_EV_NB_LAST: begin
				nb_we    = 1'b1;
				nb_waddr = AW'(FLY_COUNT - 2);
			end
			ST_EV_NB_END: begin
				nb_we    = 1'b1;
				nb_waddr = AW'(FLY_COUNT - 1);
				nb_left  = win_q[1];
				nb_right = first0_q;
			end
			ST_EV_NB_ZERO: begin
				nb_we    = 1'b1;
				nb_waddr = '0;
				nb_left  = win_q[0];
				nb_right = first1_q;
				finish   = 1'b1;
			end
			ST_UP_MUL: begin
				if (kind_q == REQ_CHECK) begin
					fly_we    = 1'b1;
					fly_wdata = oor ? {2'd0, fresh_q} : x_cur;
					res_repl  = oor;
					finish    = 1'b1;
				end else if (disturb_q) begin
					fly_we    = 1'b1;
					fly_wdata = {2'd0, fresh_q};
					res_repl  = 1'b1;
					finish    = 1'b1;
				end
			end
			ST_UP_ADD: begin
				fly_we    = 1'b1;
				fly_wdata = sat_d;
				finish    = 1'b1;
			end
			default: begin
			end
		endcase
		res_pos = fly_we ? fly_wdata : '0;
	end

	dfss_ram #(
		.WIDTH (POS_W),
		.DEPTH (FLY_COUNT)
	) u_fly_ram (
		.clk   (clk),
		.we    (fly_we),
		.waddr (idx_q),
		.wdata (fly_wdata),
		.raddr (fly_raddr),
		.rdata (fly_rdata)
	);

	dfss_ram #(
		.WIDTH (COORD_W),
		.DEPTH (FLY_COUNT)
	) u_nb_ram (
		.clk   (clk),
		.we    (nb_we),
		.waddr (nb_waddr),
		.wdata (nb_wdata),
		.raddr (fly_raddr),
		.rdata (nb_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			fly_vld_q  <= '0;
			best_pos_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_EV_FIT) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (fly_we) begin
				fly_vld_q[idx_q] <= 1'b1;
			end
			if ((state_q == ST_EV_FIT) && ((cnt_q == '0) || (cur_eval.fit < best_fit_q))) begin
				best_pos_q <= cur_eval.pos;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		fly_vld_rd_q <= fly_vld_q[fly_raddr];
		if (accept) begin
			kind_q    <= req_type;
			idx_q     <= AW'(fly_index);
			target_q  <= target_position;
			fresh_q   <= fresh_position;
			disturb_q <= (reset_draw < reset_chance_q);
			frac_q    <= step_fraction;
		end
		if (state_q == ST_EV_FIT) begin
			win_q[2] <= win_q[1];
			win_q[1] <= win_q[0];
			win_q[0] <= cur_eval;
			if ((cnt_q == '0) || (cur_eval.fit < best_fit_q)) begin
				best_fit_q <= cur_eval.fit;
			end
			if (cnt_q == CW'(0)) begin
				first0_q <= cur_eval;
			end
			if (cnt_q == CW'(1)) begin
				first1_q <= cur_eval;
			end
		end
		if (state_q == ST_UP_MUL) begin
			prod_q <= prod_d;
			nb_q   <= nb_rdata;
		end
		if (finish) begin
			fly_position_q <= res_pos;
			best_out_q     <= best_pos_q;
			replaced_q     <= res_repl;
		end
	end

	assign done          = done_q;
	assign fly_position  = fly_position_q;
	assign best_position = best_out_q;
	assign was_replaced  = replaced_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dfss_ram.sv
`default_nettype none

module dfss_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
